// ===== rtl/core/mfap_pkg.sv =====
// ----------------------------------------------------------------------------
// mfap_pkg
// shared constants, codes and types of the max-flow engine
// ----------------------------------------------------------------------------
package mfap_pkg;

   localparam int MAX_VERTICES  = 16;
   localparam int CAPACITY_BITS = 16;

   // fixed field widths of the item and register formats
   localparam int VERTEX_W   = 4;
   localparam int CAPFIELD_W = 16;
   localparam int VCOUNT_W   = 5;
   localparam int TOTAL_W    = 20;

   // derived internal widths
   localparam int VIDX_W  = $clog2(MAX_VERTICES);
   localparam int VCNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int ADDR_W  = 2 * VIDX_W;
   localparam int DEPTH   = MAX_VERTICES * MAX_VERTICES;
   localparam int CAP_W   = CAPACITY_BITS;
   localparam int FLOW_W  = CAP_W + 1;
   localparam int RES_W   = CAP_W + 2;
   localparam int SUM_W   = ((CAP_W > TOTAL_W) ? CAP_W : TOTAL_W) + 1;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SINK   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VCOUNT = 2'd2;

   // commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_RUN   = 1'b1;

   // control from the sequencer to the matrix store
   typedef struct packed {
      logic                     cap_we;
      logic                     flow_we;
      logic                     flow_clear;
      logic [ADDR_W-1:0]        waddr;
      logic [ADDR_W-1:0]        raddr;
      logic [CAP_W-1:0]         cap_wdata;
      logic signed [FLOW_W-1:0] flow_wdata;
   } mat_ctl_type;

   // read data from the matrix store, registered, in the cycle after the address
   typedef struct packed {
      logic [CAP_W-1:0]         cap;
      logic signed [FLOW_W-1:0] flow;
   } mat_rd_type;

endpackage

// ===== rtl/core/mfap_if.sv =====
// ----------------------------------------------------------------------------
// mfap request and response channels
// valid/ready channels carrying the input and result items
// ----------------------------------------------------------------------------
interface mfap_req_if;
   import mfap_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  command;
   logic [VERTEX_W-1:0]   from_vertex;
   logic [VERTEX_W-1:0]   to_vertex;
   logic [CAPFIELD_W-1:0] capacity;
   modport source (output valid, command, from_vertex, to_vertex, capacity, input ready);
   modport sink   (input valid, command, from_vertex, to_vertex, capacity, output ready);
endinterface

interface mfap_rsp_if;
   import mfap_pkg::*;
   logic               valid;
   logic               ready;
   logic [TOTAL_W-1:0] total_flow;
   modport source (output valid, total_flow, input ready);
   modport sink   (input valid, total_flow, output ready);
endinterface

// ===== rtl/core/mfap_ram.sv =====
// ----------------------------------------------------------------------------
// mfap_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mfap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/core/mfap_matrix.sv =====
// ----------------------------------------------------------------------------
// mfap_matrix
// capacity and flow matrices, flow entries tracked by per-entry valid bits
// ----------------------------------------------------------------------------
module mfap_matrix (
   input  logic                 clock,
   input  logic                 reset,
   input  mfap_pkg::mat_ctl_type ctl,
   output mfap_pkg::mat_rd_type  rd
);
   import mfap_pkg::*;

   logic [DEPTH-1:0]  flow_vld_ff, flow_vld_in;
   logic              flow_ok_ff;
   logic [CAP_W-1:0]  cap_raw;
   logic [FLOW_W-1:0] flow_raw;

   mfap_ram #(.WIDTH(CAP_W), .DEPTH(DEPTH)) u_cap_ram (
      .clock(clock), .we(ctl.cap_we), .waddr(ctl.waddr), .wdata(ctl.cap_wdata),
      .raddr(ctl.raddr), .rdata(cap_raw)
   );

   mfap_ram #(.WIDTH(FLOW_W), .DEPTH(DEPTH)) u_flow_ram (
      .clock(clock), .we(ctl.flow_we), .waddr(ctl.waddr), .wdata(ctl.flow_wdata),
      .raddr(ctl.raddr), .rdata(flow_raw)
   );

   always_comb begin
      flow_vld_in = flow_vld_ff;
      if (ctl.flow_clear) begin
         flow_vld_in = '0;
      end else if (ctl.flow_we) begin
         flow_vld_in[ctl.waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flow_vld_ff <= '0;
         flow_ok_ff  <= 1'b0;
      end else begin
         flow_vld_ff <= flow_vld_in;
         flow_ok_ff  <= flow_vld_ff[ctl.raddr];
      end
   end

   // capacity ram is zeroed by the clearing pass, flow entries not written
   // since the run began read as zero
   assign rd.cap  = cap_raw;
   assign rd.flow = flow_ok_ff ? $signed(flow_raw) : '0;
endmodule

// ===== rtl/core/max_flow_augmenting_path.sv =====
// ----------------------------------------------------------------------------
// max_flow_augmenting_path
// breadth-first augmenting-path max-flow engine on an adjacency matrix
// ----------------------------------------------------------------------------
//  channel    dir  handshake        payload
//  req_chan   in   valid/ready      command, from_vertex, to_vertex, capacity
//  rsp_chan   out  valid/ready      total_flow
//  csr_*      in   write enable     csr_index, csr_write_data
//
//  a capacity write leaves req_chan.ready high
//  after a run item is taken, each search scans the row of every dequeued
//  vertex, then walks a found path back edge by edge; the result loads last;
//  the matrix ram read port sets the pace, one entry per cycle;
//  req_chan.ready is low for the whole run
//  the result waits in an output register, so writes are taken meanwhile;
//  a run that ends while the previous result is still stalled waits for it
//  after reset a clearing pass zeroes all 256 entries of the capacity ram,
//  with req_chan.ready low
// ----------------------------------------------------------------------------
module max_flow_augmenting_path (
   input  logic                              clock,
   input  logic                              reset,
   mfap_req_if.sink                          req_chan,
   mfap_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [mfap_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mfap_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import mfap_pkg::*;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_INIT    = 4'd1;
   localparam logic [3:0] ST_POP     = 4'd2;
   localparam logic [3:0] ST_SCAN    = 4'd3;
   localparam logic [3:0] ST_DRAIN   = 4'd4;
   localparam logic [3:0] ST_END     = 4'd5;
   localparam logic [3:0] ST_AUG_RD  = 4'd6;
   localparam logic [3:0] ST_AUG_WR1 = 4'd7;
   localparam logic [3:0] ST_AUG_WR2 = 4'd8;
   localparam logic [3:0] ST_DONE    = 4'd9;
   localparam logic [3:0] ST_CLEAR   = 4'd10;

   // configuration registers
   logic [VERTEX_W-1:0] source_ff;
   logic [VERTEX_W-1:0] sink_ff;
   logic [VCOUNT_W-1:0] vcount_ff;

   // sequencer state
   logic [3:0]          state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [VCNT_W-1:0]   n_ff, n_in, n_calc;
   logic [VIDX_W-1:0]   s_ff, s_in, t_ff, t_in;
   logic [VIDX_W-1:0]   u_ff, u_in;
   logic [VIDX_W-1:0]   v_ff, v_in;
   logic [VIDX_W-1:0]   pv_ff, pv_in;
   logic                pend_ff, pend_in;
   logic [CAP_W-1:0]    bu_ff, bu_in;
   logic [CAP_W-1:0]    amt_ff, amt_in;
   logic [VCNT_W-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;

   // search tables
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [CAP_W-1:0]        bott_ff [MAX_VERTICES];
   logic [CAP_W-1:0]        bott_in [MAX_VERTICES];
   logic [VIDX_W-1:0]       pred_ff [MAX_VERTICES];
   logic [VIDX_W-1:0]       pred_in [MAX_VERTICES];
   logic [VIDX_W-1:0]       queue_ff [MAX_VERTICES];
   logic [VIDX_W-1:0]       queue_in [MAX_VERTICES];

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0] rsp_data_ff, rsp_data_in;

   mat_ctl_type ctl;
   mat_rd_type  rd;

   logic signed [RES_W-1:0] res;
   logic [CAP_W-1:0]        bmin;
   logic [SUM_W-1:0]        sum;
   logic [VIDX_W-1:0]       qhead;

   mfap_matrix u_matrix (.clock(clock), .reset(reset), .ctl(ctl), .rd(rd));

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.total_flow = rsp_data_ff;

   // vertex count clamped to one..MAX_VERTICES
   always_comb begin
      if (vcount_ff == '0) begin
         n_calc = VCNT_W'(1);
      end else if (int'(vcount_ff) > MAX_VERTICES) begin
         n_calc = VCNT_W'(MAX_VERTICES);
      end else begin
         n_calc = VCNT_W'(vcount_ff);
      end
   end

   // residual capacity of the entry read last cycle, and path bottleneck
   assign res = $signed({2'b00, rd.cap}) - $signed({{(RES_W-FLOW_W){rd.flow[FLOW_W-1]}}, rd.flow});
   assign bmin = (res < $signed({2'b00, bu_ff})) ? CAP_W'(res) : bu_ff;
   assign sum = SUM_W'(total_ff) + SUM_W'(amt_ff);
   assign qhead = head_ff[VIDX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      n_in         = n_ff;
      s_in         = s_ff;
      t_in         = t_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      pv_in        = v_ff;
      pend_in      = 1'b0;
      bu_in        = bu_ff;
      amt_in       = amt_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      total_in     = total_ff;
      visited_in   = visited_ff;
      bott_in      = bott_ff;
      pred_in      = pred_ff;
      queue_in     = queue_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      ctl            = '0;
      ctl.raddr      = {u_ff, v_ff};
      ctl.cap_wdata  = CAP_W'(req_chan.capacity);

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // evaluate the edge read in the previous scan cycle
      if (pend_ff) begin
         if (res > 0 && !visited_ff[pv_ff] && int'(tail_ff) < MAX_VERTICES) begin
            visited_in[pv_ff]                 = 1'b1;
            pred_in[pv_ff]                    = u_ff;
            bott_in[pv_ff]                    = bmin;
            queue_in[tail_ff[VIDX_W-1:0]]     = pv_ff;
            tail_in                           = tail_ff + VCNT_W'(1);
            if (pv_ff == t_ff) begin
               amt_in = bmin;
            end
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            // zero one capacity entry per cycle after reset
            ctl.cap_we    = 1'b1;
            ctl.waddr     = clr_ff;
            ctl.cap_wdata = '0;
            clr_in        = clr_ff + ADDR_W'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.command == CMD_WRITE) begin
                  if (int'(req_chan.from_vertex) < MAX_VERTICES &&
                      int'(req_chan.to_vertex) < MAX_VERTICES) begin
                     ctl.cap_we = 1'b1;
                     ctl.waddr  = {VIDX_W'(req_chan.from_vertex), VIDX_W'(req_chan.to_vertex)};
                  end
               end else begin
                  ctl.flow_clear = 1'b1;
                  total_in = '0;
                  n_in     = n_calc;
                  s_in     = VIDX_W'(source_ff);
                  t_in     = VIDX_W'(sink_ff);
                  if (source_ff != sink_ff && int'(source_ff) < int'(n_calc) &&
                      int'(sink_ff) < int'(n_calc)) begin
                     state_in = ST_INIT;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_INIT: begin
            visited_in       = '0;
            visited_in[s_ff] = 1'b1;
            bott_in[s_ff]    = '1;
            queue_in[0]      = s_ff;
            head_in          = '0;
            tail_in          = VCNT_W'(1);
            amt_in           = '0;
            state_in         = ST_POP;
         end
         ST_POP: begin
            if (head_ff == tail_ff) begin
               state_in = ST_END;
            end else begin
               u_in     = queue_ff[qhead];
               bu_in    = bott_ff[queue_ff[qhead]];
               head_in  = head_ff + VCNT_W'(1);
               v_in     = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // one matrix entry per cycle along row u
            pend_in = 1'b1;
            v_in    = v_ff + VIDX_W'(1);
            if (VCNT_W'(v_ff) == n_ff - VCNT_W'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_POP;
         end
         ST_END: begin
            if (visited_ff[t_ff]) begin
               total_in = (sum > SUM_W'({TOTAL_W{1'b1}})) ? '1 : TOTAL_W'(sum);
               v_in     = t_ff;
               state_in = ST_AUG_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_AUG_RD: begin
            // walk back from the sink, one path edge per pass through AUG_RD, AUG_WR1 and AUG_WR2
            u_in      = pred_ff[v_ff];
            ctl.raddr = {pred_ff[v_ff], v_ff};
            state_in  = ST_AUG_WR1;
         end
         ST_AUG_WR1: begin
            ctl.flow_we    = 1'b1;
            ctl.waddr      = {u_ff, v_ff};
            ctl.flow_wdata = FLOW_W'(rd.flow + $signed({1'b0, amt_ff}));
            ctl.raddr      = {v_ff, u_ff};
            state_in       = ST_AUG_WR2;
         end
         ST_AUG_WR2: begin
            ctl.flow_we    = 1'b1;
            ctl.waddr      = {v_ff, u_ff};
            ctl.flow_wdata = FLOW_W'(rd.flow - $signed({1'b0, amt_ff}));
            v_in           = u_ff;
            state_in       = (u_ff == s_ff) ? ST_INIT : ST_AUG_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = total_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         source_ff    <= '0;
         sink_ff      <= VERTEX_W'(1);
         vcount_ff    <= VCOUNT_W'(16);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_SOURCE: source_ff <= csr_write_data[VERTEX_W-1:0];
               CSR_SINK:   sink_ff   <= csr_write_data[VERTEX_W-1:0];
               CSR_VCOUNT: vcount_ff <= csr_write_data[VCOUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      s_ff        <= s_in;
      t_ff        <= t_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      pv_ff       <= pv_in;
      bu_ff       <= bu_in;
      amt_ff      <= amt_in;
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      total_ff    <= total_in;
      visited_ff  <= visited_in;
      bott_ff     <= bott_in;
      pred_ff     <= pred_in;
      queue_ff    <= queue_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule

// ===== rtl/core/mfap_checker.sv =====
// ----------------------------------------------------------------------------
// mfap_checker
// port-level checks of the max-flow engine, bound to the top level
// ----------------------------------------------------------------------------
module mfap_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_command,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [mfap_pkg::TOTAL_W-1:0] rsp_total_flow
);
   import mfap_pkg::*;

   // a run makes the block busy
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == CMD_RUN |=> !req_ready)
      else $error("ready high after a run item");

   // a result only appears when a run was in progress
   a_rsp_after_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result without a run");

   // writes never produce a result on their own
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid && req_ready && req_command == CMD_WRITE |=> !rsp_valid)
      else $error("result after a write item");

   // result holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total_flow))
      else $error("stalled result changed");
endmodule

bind max_flow_augmenting_path mfap_checker u_mfap_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .req_command(req_chan.command),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_total_flow(rsp_chan.total_flow)
);
